### rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the contact row core.
// Each macro takes a label, an antecedent and a consequent; clk and rst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CRAR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("contact row core: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define CRAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("contact row core: next-cycle check failed");

// next-cycle implication that is also checked across reset
`define CRAR_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("contact row core: reset check failed");

`endif

### rtl/core/crar_pkg.sv
// Shared types, constants and helpers of the contact row acceleration core.
// No dependencies; imported by the front, back and top level modules.
package crar_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 63;  // accumulator, holds +-2^60 plus three products
  localparam int OPND_W    = 33;  // multiplier operand, holds the negated minimum
  localparam int WIDE_W    = 2 * OPND_W;

  localparam logic signed [31:0] S32_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q       = 32'(64'sd1 << FRAC_BITS);
  localparam logic signed [31:0] CAP_Q       = 32'(64'sd4 << FRAC_BITS);
  localparam int                 SMALL_PEN_I = ((1 << FRAC_BITS) + 500) / 1000;
  localparam logic signed [31:0] SMALL_PEN_Q = 32'(SMALL_PEN_I);
  localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(64'sd1 << 60);

  // configuration register indexes
  localparam logic [1:0] REG_TIME_STEP     = 2'd0;
  localparam logic [1:0] REG_INV_TIME_STEP = 2'd1;
  localparam logic [1:0] REG_PEN_THRESHOLD = 2'd2;

  // input operation and the slot that ends a row
  localparam logic       OP_LOAD      = 1'b0;
  localparam logic [1:0] SLOT_ROW_END = 2'd3;

  // item classes decided by the front end
  typedef logic [1:0] kind_t;
  localparam kind_t K_LOAD = 2'd0;  // store a body velocity vector
  localparam kind_t K_PART = 2'd1;  // accumulate, row continues
  localparam kind_t K_END  = 2'd2;  // accumulate, row ends with a result
  localparam kind_t K_SKIP = 2'd3;  // accumulate, row ends without result

  typedef struct packed {
    kind_t              kind;
    logic [1:0]         slot;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] rest;
    logic signed [31:0] pen;
    logic signed [31:0] stiff;
    logic signed [31:0] daccel;
    logic               normal;
    logic               pen_gt;   // penetration above threshold
  } q_entry_t;

  typedef struct packed {
    logic signed [31:0] ts;
    logic signed [31:0] its;
  } step_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v > WIDE_W'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < WIDE_W'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [OPND_W-1:0] sx33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

endpackage

### rtl/core/crar_front.sv
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on crar_pkg.
module crar_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [1:0]           in_part_index,
  input  logic signed [31:0]   in_comp_x,
  input  logic signed [31:0]   in_comp_y,
  input  logic signed [31:0]   in_comp_z,
  input  logic signed [31:0]   in_restitution,
  input  logic signed [31:0]   in_penetration,
  input  logic signed [31:0]   in_penetration_stiffness,
  input  logic signed [31:0]   in_delta_accel,
  input  logic                 in_is_normal_row,
  input  logic [30:0]          pen_threshold,
  output crar_pkg::q_entry_t   head,
  output logic                 head_valid,
  input  logic                 pop
);
  import crar_pkg::*;

  localparam int QDEPTH = 2;

  q_entry_t   q_mem_r [QDEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  q_entry_t   ent;
  logic       push;

  assign in_ready   = (cnt_r != 2'(QDEPTH));
  assign push       = in_valid && in_ready;
  assign head       = q_mem_r[rd_ptr_r];
  assign head_valid = (cnt_r != 2'd0);

  always_comb begin
    ent.slot   = in_part_index;
    ent.cx     = in_comp_x;
    ent.cy     = in_comp_y;
    ent.cz     = in_comp_z;
    ent.rest   = in_restitution;
    ent.pen    = in_penetration;
    ent.stiff  = in_penetration_stiffness;
    ent.daccel = in_delta_accel;
    ent.normal = in_is_normal_row;
    ent.pen_gt = (in_penetration > $signed({1'b0, pen_threshold}));
    if (in_operation == OP_LOAD) begin
      ent.kind = K_LOAD;
    end else if (in_part_index != SLOT_ROW_END) begin
      ent.kind = K_PART;
    end else if (in_restitution[31]) begin
      ent.kind = K_SKIP;
    end else begin
      ent.kind = K_END;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/core/crar_back.sv
// Back end: velocity store, dot-product accumulator and the row-end scalar sequence,
// all on one shared 33x33 multiplier, plus the result register. Depends on crar_pkg.
module crar_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crar_pkg::q_entry_t   head,
  input  logic                 head_valid,
  output logic                 pop,
  input  crar_pkg::step_cfg_t  step_cfg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_coordinate_accel,
  output logic signed [31:0]   out_new_penetration
);
  import crar_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MY   = 4'd1;
  localparam logic [3:0] ST_MZ   = 4'd2;
  localparam logic [3:0] ST_MEND = 4'd3;
  localparam logic [3:0] ST_C1   = 4'd4;
  localparam logic [3:0] ST_C2   = 4'd5;
  localparam logic [3:0] ST_C3   = 4'd6;
  localparam logic [3:0] ST_C4   = 4'd7;
  localparam logic [3:0] ST_PV   = 4'd8;
  localparam logic [3:0] ST_PV2  = 4'd9;
  localparam logic [3:0] ST_F    = 4'd10;
  localparam logic [3:0] ST_F2   = 4'd11;
  localparam logic [3:0] ST_O    = 4'd12;
  localparam logic [3:0] ST_O2   = 4'd13;

  logic [3:0]                st_r;
  q_entry_t                  ent_r;
  logic signed [31:0]        vx_r [4];
  logic signed [31:0]        vy_r [4];
  logic signed [31:0]        vz_r [4];
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [WIDE_W-1:0]  prod_r;
  logic signed [31:0]        vrel_r;
  logic signed [31:0]        pen_r;
  logic signed [31:0]        corr_r;
  logic signed [31:0]        penvel_r;
  logic                      out_valid_r;
  logic signed [31:0]        out_ca_r;
  logic signed [31:0]        out_pen_r;

  logic signed [OPND_W-1:0]  mul_a;
  logic signed [OPND_W-1:0]  mul_b;
  logic signed [WIDE_W-1:0]  mul_p;
  logic signed [WIDE_W-1:0]  fl;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [ACC_W-1:0]   acc_clamp;
  logic                      vrel_pos;
  logic signed [OPND_W-1:0]  fsum;
  logic signed [31:0]        factor;
  logic signed [WIDE_W-1:0]  pdiff;
  logic signed [31:0]        corr_c;
  logic signed [31:0]        corr8;
  logic signed [WIDE_W-1:0]  vsum;
  logic signed [31:0]        vcap;
  logic signed [31:0]        ca_val;
  logic                      out_free;

  assign out_valid            = out_valid_r;
  assign out_coordinate_accel = out_ca_r;
  assign out_new_penetration  = out_pen_r;
  assign pop                  = (st_r == ST_IDLE) && head_valid;
  assign out_free             = !out_valid_r || out_ready;

  // products are floored by the arithmetic shift
  assign fl       = prod_r >>> FRAC_BITS;
  assign vrel_pos = (vrel_r > 32'sd0);

  always_comb begin
    acc_sum = acc_r + $signed(fl[ACC_W-1:0]);
    if (acc_sum > ACC_LIM) begin
      acc_clamp = ACC_LIM;
    end else if (acc_sum < -ACC_LIM) begin
      acc_clamp = -ACC_LIM;
    end else begin
      acc_clamp = acc_sum;
    end

    fsum = sx33(ent_r.rest) + sx33(ONE_Q);
    if (vrel_pos) begin
      factor = ONE_Q;
    end else if (fsum > sx33(S32_MAX)) begin
      factor = S32_MAX;
    end else begin
      factor = fsum[31:0];
    end

    pdiff  = WIDE_W'(pen_r) - fl;
    corr_c = sat32(fl);
    corr8  = sat32(WIDE_W'(corr_c) <<< 3);
    vsum   = WIDE_W'(sat32(fl)) + WIDE_W'(penvel_r);
    vcap   = (vsum > WIDE_W'(CAP_Q)) ? CAP_Q : sat32(vsum);
    ca_val = sat32(WIDE_W'(ent_r.daccel) - fl);
  end

  // operand select for the shared multiplier
  always_comb begin
    case (st_r)
      ST_IDLE: begin
        mul_a = sx33(head.cx);
        mul_b = sx33(vx_r[head.slot]);
      end
      ST_MY: begin
        mul_a = sx33(ent_r.cy);
        mul_b = sx33(vy_r[ent_r.slot]);
      end
      ST_MZ: begin
        mul_a = sx33(ent_r.cz);
        mul_b = sx33(vz_r[ent_r.slot]);
      end
      ST_C1: begin
        mul_a = vrel_pos ? sx33(vrel_r) : -sx33(vrel_r);
        mul_b = sx33(step_cfg.ts);
      end
      ST_C3: begin
        mul_a = sx33(corr_r);
        mul_b = sx33(ent_r.rest);
      end
      ST_PV: begin
        mul_a = sx33(pen_r);
        mul_b = sx33(ent_r.stiff);
      end
      ST_F: begin
        mul_a = sx33(vrel_r);
        mul_b = sx33(factor);
      end
      default: begin
        mul_a = sx33(vrel_r);
        mul_b = sx33(step_cfg.its);
      end
    endcase
  end

  assign mul_p = WIDE_W'(mul_a) * WIDE_W'(mul_b);

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (st_r != ST_O2) begin
      prod_r <= mul_p;
    end
    if (pop) begin
      ent_r <= head;
    end
    case (st_r)
      ST_MEND: begin
        vrel_r   <= sat32(WIDE_W'(acc_clamp));
        pen_r    <= ent_r.pen;
        penvel_r <= 32'sd0;
      end
      ST_C2: begin
        if (vrel_pos) begin
          pen_r <= (pdiff < 0) ? 32'sd0 : pdiff[31:0];
        end else begin
          corr_r <= sat32(fl);
        end
      end
      ST_C4: begin
        if (corr8 > pen_r) begin
          pen_r <= SMALL_PEN_Q;
        end
      end
      ST_PV2: penvel_r <= sat32(-fl);
      ST_F2:  vrel_r   <= vcap;
      ST_O2: begin
        if (out_free) begin
          out_ca_r  <= ca_val;
          out_pen_r <= pen_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        vx_r[i] <= '0;
        vy_r[i] <= '0;
        vz_r[i] <= '0;
      end
    end else begin
      // load a new result, or drop the one the receiver took
      if ((st_r == ST_O2) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (head_valid) begin
            if (head.kind == K_LOAD) begin
              vx_r[head.slot] <= head.cx;
              vy_r[head.slot] <= head.cy;
              vz_r[head.slot] <= head.cz;
            end else begin
              st_r <= ST_MY;
            end
          end
        end
        ST_MY: begin
          acc_r <= acc_sum;
          st_r  <= ST_MZ;
        end
        ST_MZ: begin
          acc_r <= acc_sum;
          st_r  <= ST_MEND;
        end
        ST_MEND: begin
          if (ent_r.kind == K_PART) begin
            acc_r <= acc_clamp;
            st_r  <= ST_IDLE;
          end else begin
            // row ends: clear the accumulator also for a skipped row
            acc_r <= '0;
            if (ent_r.kind == K_SKIP) begin
              st_r <= ST_IDLE;
            end else if (!ent_r.normal) begin
              st_r <= ST_O;
            end else if (ent_r.pen_gt) begin
              st_r <= ST_C1;
            end else begin
              st_r <= ST_F;
            end
          end
        end
        ST_C1: st_r <= ST_C2;
        ST_C2: st_r <= vrel_pos ? ST_PV : ST_C3;
        ST_C3: st_r <= ST_C4;
        ST_C4: st_r <= ST_PV;
        ST_PV: st_r <= ST_PV2;
        ST_PV2: st_r <= ST_F;
        ST_F:  st_r <= ST_F2;
        ST_F2: st_r <= ST_O;
        ST_O:  st_r <= ST_O2;
        ST_O2: begin
          // hold until the result register is free
          if (out_free) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/contact_row_accel_restitution_core.sv
// A load item writes the velocity store; a row part passes IDLE, MY, MZ and MEND to the
// accumulator update. A result row end goes to O and O2 on a plain row, via F and F2 on a
// normal row, and via C1 to PV2 before F with correction. One shared 33x33 multiplier forms
// the three products. Items pop only in IDLE; the two-entry queue lets input run ahead.
// Reset (synchronous, rst_n low): registers to their reset values, velocities and
// accumulator to zero, queue and result register empty. No clearing pass.
module contact_row_accel_restitution_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [1:0]           in_part_index,
  input  logic signed [31:0]   in_comp_x,
  input  logic signed [31:0]   in_comp_y,
  input  logic signed [31:0]   in_comp_z,
  input  logic signed [31:0]   in_restitution,
  input  logic signed [31:0]   in_penetration,
  input  logic signed [31:0]   in_penetration_stiffness,
  input  logic signed [31:0]   in_delta_accel,
  input  logic                 in_is_normal_row,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_coordinate_accel,
  output logic signed [31:0]   out_new_penetration
);
  import crar_pkg::*;

  logic signed [31:0] time_step_r;
  logic signed [31:0] inv_time_step_r;
  logic [30:0]        pen_threshold_r;
  step_cfg_t          step_cfg;
  q_entry_t           head;
  logic               head_valid;
  logic               pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r     <= 32'sd0;
      inv_time_step_r <= ONE_Q;
      pen_threshold_r <= 31'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP:     time_step_r     <= cfg_wdata;
        REG_INV_TIME_STEP: inv_time_step_r <= cfg_wdata;
        REG_PEN_THRESHOLD: pen_threshold_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // a non-positive step selects 1.0 for both step values
  always_comb begin
    if (time_step_r > 32'sd0) begin
      step_cfg.ts  = time_step_r;
      step_cfg.its = inv_time_step_r;
    end else begin
      step_cfg.ts  = ONE_Q;
      step_cfg.its = ONE_Q;
    end
  end

  crar_front u_front (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_operation             (in_operation),
    .in_part_index            (in_part_index),
    .in_comp_x                (in_comp_x),
    .in_comp_y                (in_comp_y),
    .in_comp_z                (in_comp_z),
    .in_restitution           (in_restitution),
    .in_penetration           (in_penetration),
    .in_penetration_stiffness (in_penetration_stiffness),
    .in_delta_accel           (in_delta_accel),
    .in_is_normal_row         (in_is_normal_row),
    .pen_threshold            (pen_threshold_r),
    .head                     (head),
    .head_valid               (head_valid),
    .pop                      (pop)
  );

  crar_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .head_valid           (head_valid),
    .pop                  (pop),
    .step_cfg             (step_cfg),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_coordinate_accel (out_coordinate_accel),
    .out_new_penetration  (out_new_penetration)
  );

endmodule

### rtl/core/crar_checker.sv
// Port-level checks for the contact row core, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module crar_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_coordinate_accel,
  input logic signed [31:0] out_new_penetration
);

  logic [63:0] out_payload;

  assign out_payload = {out_coordinate_accel, out_new_penetration};

  // reset empties the queue and the result register
  `CRAR_ASSERT_RST(a_reset_empty, !rst_n, in_ready && !out_valid)
  // a stalled result stays valid
  `CRAR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // a stalled result keeps its payload
  `CRAR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_payload))
  // with no item offered the queue cannot fill
  `CRAR_ASSERT_NEXT(a_ready_hold, in_ready && !in_valid, in_ready)

endmodule

bind contact_row_accel_restitution_core crar_checker u_crar_checker (.*);
